FILE: design/mbps_pkg.sv
// Shared constants, codes and types of the masked byte pattern scanner.
package mbps_pkg;

    // Sizing
    localparam int MAX_PATTERN = 32;
    localparam int POS_BITS    = 32;
    localparam int BYTE_W      = 8;
    localparam int IDX_W       = $clog2(MAX_PATTERN);
    localparam int EFF_W       = $clog2(MAX_PATTERN + 1);

    // Field widths
    localparam int ACTION_W    = 2;
    localparam int PIDX_W      = 5;
    localparam int OFFSET_W    = 32;
    localparam int LEN_CFG_W   = 6;
    localparam int CFG_W       = 6;
    localparam int CFG_IDX_W   = 1;

    // Match starts may be restricted to multiples of this step
    localparam int ALIGN_STEP  = 4;
    localparam int ALIGN_W     = $clog2(ALIGN_STEP);

    // Action codes
    localparam logic [ACTION_W-1:0] ACT_LOAD    = 2'd0;
    localparam logic [ACTION_W-1:0] ACT_SCAN    = 2'd1;
    localparam logic [ACTION_W-1:0] ACT_RESTART = 2'd2;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_PATTERN_LENGTH = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ALIGNED_STARTS = 1'd1;

    // One pattern entry
    typedef struct packed {
        logic [BYTE_W-1:0] value;
        logic [BYTE_W-1:0] mask;
    } t_pat;

    // Controls broadcast to every cell
    typedef struct packed {
        logic scan;
        logic clear;
        logic rotate;
    } t_cell_ctl;

endpackage

FILE: design/mbps_in_if.sv
// Input channel of the scanner: pattern loads, data bytes and restarts.
interface mbps_in_if;
    logic                               valid;
    logic                               ready;
    logic [mbps_pkg::ACTION_W-1:0]      action;
    logic [mbps_pkg::PIDX_W-1:0]        pattern_index;
    logic [mbps_pkg::BYTE_W-1:0]        pattern_value;
    logic [mbps_pkg::BYTE_W-1:0]        pattern_mask;
    logic [mbps_pkg::BYTE_W-1:0]        data_byte;
    logic                               is_last;

    modport source (
        output valid, action, pattern_index, pattern_value, pattern_mask, data_byte, is_last,
        input  ready
    );
    modport sink (
        input  valid, action, pattern_index, pattern_value, pattern_mask, data_byte, is_last,
        output ready
    );
endinterface

FILE: design/mbps_out_if.sv
// Result channel of the scanner.
interface mbps_out_if;
    logic                               valid;
    logic                               ready;
    logic                               match_found;
    logic [mbps_pkg::OFFSET_W-1:0]      match_offset;
    logic                               search_done;

    modport source (
        output valid, match_found, match_offset, search_done,
        input  ready
    );
    modport sink (
        input  valid, match_found, match_offset, search_done,
        output ready
    );
endinterface

FILE: design/masked_byte_pattern_scan.sv
// Top level of the masked byte pattern scanner: cell row, position tracking and result pipe.
//
// Takes one beat per clock unless a realignment or a stalled result side holds input
// ready low: a pattern load, a data byte or a restart. It returns one result beat for
// each, registered in stage 1 and then in the output register. A row of MAX_PATTERN
// cells holds the byte history and the pattern entries, so every masked compare of the
// window runs in parallel; the per-cell hits are registered and reduced in the next stage,
// where the first-match decision is made. Pattern entries sit in the cells already lined
// up for the current pattern_length. After a write to pattern_length the row rotates its
// entries one cell per cycle until they line up again; input ready stays low meanwhile.
module masked_byte_pattern_scan (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [mbps_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [mbps_pkg::CFG_W-1:0]      i_cfg_data,
    mbps_in_if.sink                         i_in,
    mbps_out_if.source                      o_out
);

    localparam int CMP_W = (mbps_pkg::LEN_CFG_W > mbps_pkg::EFF_W) ?
                           mbps_pkg::LEN_CFG_W : mbps_pkg::EFF_W;
    localparam int PIDX_CMP_W = ((mbps_pkg::PIDX_W > mbps_pkg::IDX_W) ?
                                 mbps_pkg::PIDX_W : mbps_pkg::IDX_W) + 1;

    // Configuration registers
    logic [mbps_pkg::LEN_CFG_W-1:0] r_len_cfg;
    logic                           r_align;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len_cfg <= mbps_pkg::LEN_CFG_W'(1);
            r_align   <= 1'b0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                mbps_pkg::CFG_PATTERN_LENGTH: r_len_cfg <= i_cfg_data[mbps_pkg::LEN_CFG_W-1:0];
                mbps_pkg::CFG_ALIGNED_STARTS: r_align   <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    // Effective length: zero acts as one, oversize clamps to the row length
    logic [CMP_W-1:0]              len_x;
    logic [mbps_pkg::EFF_W-1:0]    eff_len;
    logic [mbps_pkg::IDX_W-1:0]    rot_target;

    always_comb begin
        len_x = CMP_W'(r_len_cfg);
        if (len_x == '0) begin
            eff_len = mbps_pkg::EFF_W'(1);
        end else if (len_x > CMP_W'(mbps_pkg::MAX_PATTERN)) begin
            eff_len = mbps_pkg::EFF_W'(mbps_pkg::MAX_PATTERN);
        end else begin
            eff_len = mbps_pkg::EFF_W'(len_x);
        end
        rot_target = (eff_len == mbps_pkg::EFF_W'(mbps_pkg::MAX_PATTERN)) ?
                     '0 : mbps_pkg::IDX_W'(eff_len);
    end

    // Ring alignment: cell k holds pattern entry (r_rot - 1 - k) mod MAX_PATTERN
    logic [mbps_pkg::IDX_W-1:0] r_rot;
    logic                       rotating;

    assign rotating = (r_rot != rot_target);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rot <= mbps_pkg::IDX_W'(1);
        end else if (rotating) begin
            r_rot <= (r_rot == mbps_pkg::IDX_W'(mbps_pkg::MAX_PATTERN - 1)) ?
                     '0 : r_rot + 1'b1;
        end
    end

    // Handshake and pipe control
    logic r_s1_v;
    logic r_out_v;
    logic out_en;
    logic s1_en;
    logic in_acc;
    logic is_scan;
    logic is_load;
    logic is_restart;

    assign out_en     = !r_out_v || o_out.ready;
    assign s1_en      = !r_s1_v || out_en;
    assign i_in.ready = s1_en && !rotating;
    assign in_acc     = i_in.valid && i_in.ready;
    assign is_scan    = in_acc && (i_in.action == mbps_pkg::ACT_SCAN);
    assign is_load    = in_acc && (i_in.action == mbps_pkg::ACT_LOAD);
    assign is_restart = in_acc && (i_in.action == mbps_pkg::ACT_RESTART);

    // Cell address of a pattern load
    logic                          idx_ok;
    logic [mbps_pkg::IDX_W:0]      addr_sum;
    logic [mbps_pkg::IDX_W-1:0]    load_addr;

    always_comb begin
        idx_ok   = PIDX_CMP_W'(i_in.pattern_index) < PIDX_CMP_W'(mbps_pkg::MAX_PATTERN);
        addr_sum = {1'b0, r_rot} + (mbps_pkg::IDX_W + 1)'(mbps_pkg::MAX_PATTERN - 1)
                 - (mbps_pkg::IDX_W + 1)'(i_in.pattern_index);
        if (addr_sum >= (mbps_pkg::IDX_W + 1)'(mbps_pkg::MAX_PATTERN)) begin
            load_addr = mbps_pkg::IDX_W'(addr_sum - (mbps_pkg::IDX_W + 1)'(mbps_pkg::MAX_PATTERN));
        end else begin
            load_addr = mbps_pkg::IDX_W'(addr_sum);
        end
    end

    // Byte position and window eligibility
    logic [mbps_pkg::POS_BITS-1:0] r_pos;
    logic [mbps_pkg::POS_BITS-1:0] len_m1;
    logic [mbps_pkg::POS_BITS-1:0] start;
    logic                          pos_open;
    logic                          elig;

    always_comb begin
        len_m1   = mbps_pkg::POS_BITS'(eff_len - 1'b1);
        start    = r_pos - len_m1;
        pos_open = (r_pos != '1);
        elig     = pos_open && (r_pos >= len_m1) &&
                   (!r_align || (start[mbps_pkg::ALIGN_W-1:0] == '0));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos <= '0;
        end else if (is_restart) begin
            r_pos <= '0;
        end else if (is_scan && pos_open) begin
            r_pos <= r_pos + 1'b1;
        end
    end

    // Cell row
    mbps_pkg::t_cell_ctl          cell_ctl;
    mbps_pkg::t_pat               load_pat;
    logic [mbps_pkg::BYTE_W-1:0]  hist [mbps_pkg::MAX_PATTERN];
    mbps_pkg::t_pat               pats [mbps_pkg::MAX_PATTERN];
    logic [mbps_pkg::MAX_PATTERN-1:0] hits;

    assign cell_ctl.scan   = is_scan;
    assign cell_ctl.clear  = is_restart;
    assign cell_ctl.rotate = rotating;
    assign load_pat.value  = i_in.pattern_value;
    assign load_pat.mask   = i_in.pattern_mask;

    for (genvar k = 0; k < mbps_pkg::MAX_PATTERN; k++) begin : g_cell
        logic [mbps_pkg::BYTE_W-1:0] prev_byte;
        mbps_pkg::t_pat              prev_pat;
        logic                        active;
        logic                        load_en;

        if (k == 0) begin : g_head
            assign prev_byte = i_in.data_byte;
            assign prev_pat  = pats[mbps_pkg::MAX_PATTERN-1];
        end else begin : g_body
            assign prev_byte = hist[k-1];
            assign prev_pat  = pats[k-1];
        end

        assign active  = mbps_pkg::EFF_W'(k) < eff_len;
        assign load_en = is_load && idx_ok && (load_addr == mbps_pkg::IDX_W'(k));

        mbps_cell u_cell (
            .i_clk       (i_clk),
            .i_rst_n     (i_rst_n),
            .i_ctl       (cell_ctl),
            .i_load      (load_en),
            .i_load_pat  (load_pat),
            .i_active    (active),
            .i_prev_byte (prev_byte),
            .i_prev_pat  (prev_pat),
            .o_byte      (hist[k]),
            .o_pat       (pats[k]),
            .o_hit       (hits[k])
        );
    end

    // Stage 1: registered hits and window context
    logic                              r_s1_scan;
    logic                              r_s1_restart;
    logic                              r_s1_elig;
    logic                              r_s1_last;
    logic [mbps_pkg::OFFSET_W-1:0]     r_s1_start;
    logic [mbps_pkg::MAX_PATTERN-1:0]  r_s1_hits;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_v <= 1'b0;
        end else if (s1_en) begin
            r_s1_v <= in_acc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_s1_scan    <= (i_in.action == mbps_pkg::ACT_SCAN);
            r_s1_restart <= (i_in.action == mbps_pkg::ACT_RESTART);
            r_s1_elig    <= elig;
            r_s1_last    <= i_in.is_last;
            r_s1_start   <= mbps_pkg::OFFSET_W'(start);
            r_s1_hits    <= hits;
        end
    end

    // First-match decision, in beat order
    logic r_found;
    logic s1_found;
    logic s1_done;

    assign s1_found = r_s1_scan && r_s1_elig && !r_found && (&r_s1_hits);
    assign s1_done  = r_s1_scan && (s1_found || r_s1_last);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_found <= 1'b0;
        end else if (out_en && r_s1_v) begin
            if (r_s1_restart) begin
                r_found <= 1'b0;
            end else if (s1_found) begin
                r_found <= 1'b1;
            end
        end
    end

    // Output register
    logic                          r_out_found;
    logic [mbps_pkg::OFFSET_W-1:0] r_out_offset;
    logic                          r_out_done;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v <= 1'b0;
        end else if (out_en) begin
            r_out_v <= r_s1_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_en && r_s1_v) begin
            r_out_found  <= s1_found;
            r_out_offset <= s1_found ? r_s1_start : '0;
            r_out_done   <= s1_done;
        end
    end

    assign o_out.valid        = r_out_v;
    assign o_out.match_found  = r_out_found;
    assign o_out.match_offset = r_out_offset;
    assign o_out.search_done  = r_out_done;

endmodule

FILE: design/mbps_cell.sv
// One window cell: a history byte, a pattern entry and its masked compare.
module mbps_cell (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  mbps_pkg::t_cell_ctl         i_ctl,
    input  logic                        i_load,
    input  mbps_pkg::t_pat              i_load_pat,
    input  logic                        i_active,
    input  logic [mbps_pkg::BYTE_W-1:0] i_prev_byte,
    input  mbps_pkg::t_pat              i_prev_pat,
    output logic [mbps_pkg::BYTE_W-1:0] o_byte,
    output mbps_pkg::t_pat              o_pat,
    output logic                        o_hit
);

    logic [mbps_pkg::BYTE_W-1:0] r_byte;
    mbps_pkg::t_pat              r_pat;

    // History shifts one cell per scanned byte
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_byte <= '0;
        end else if (i_ctl.clear) begin
            r_byte <= '0;
        end else if (i_ctl.scan) begin
            r_byte <= i_prev_byte;
        end
    end

    // Pattern entry: direct load, or one step around the ring on realignment
    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_pat <= i_load_pat;
        end else if (i_ctl.rotate) begin
            r_pat <= i_prev_pat;
        end
    end

    // Compare the byte this cell holds after the shift; unused cells always hit
    assign o_hit  = !i_active ||
                    (((i_prev_byte ^ r_pat.value) & r_pat.mask) == '0);
    assign o_byte = r_byte;
    assign o_pat  = r_pat;

endmodule

FILE: verif/tb.sv
// Self-checking testbench of the masked byte pattern scanner: directed table, then random phases.
`timescale 1ns / 100ps

module tb;
    import mbps_pkg::*;

    // Action code the block must ignore
    localparam logic [ACTION_W-1:0] ACT_UNUSED = 2'd3;
    localparam int  RANDOM_BEATS = 650;
    localparam bit  TYPED        = 1'b1;
    localparam bit  PRED         = 1'b0;

    typedef struct packed {
        logic [ACTION_W-1:0] action;
        logic [PIDX_W-1:0]   pattern_index;
        logic [BYTE_W-1:0]   pattern_value;
        logic [BYTE_W-1:0]   pattern_mask;
        logic [BYTE_W-1:0]   data_byte;
        logic                is_last;
    } t_beat;

    typedef struct packed {
        logic                match_found;
        logic [OFFSET_W-1:0] match_offset;
        logic                search_done;
    } t_scan_result;

    // One row of the directed table: a register write or an input beat
    typedef struct packed {
        logic             do_len;
        logic [CFG_W-1:0] len_val;
        logic             do_align;
        logic [CFG_W-1:0] align_val;
        t_beat            beat;
        logic             typed;
        t_scan_result     want;
    } t_row;

    logic                 clk = 1'b0;
    logic                 rst_n;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_W-1:0]     cfg_data;

    mbps_in_if  in_ch ();
    mbps_out_if out_ch ();

    masked_byte_pattern_scan uut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data),
        .i_in        (in_ch),
        .o_out       (out_ch)
    );

    // 10 ns clock
    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Scanner state as predicted
    logic [BYTE_W-1:0]    pat_value   [MAX_PATTERN];
    logic [BYTE_W-1:0]    pat_mask    [MAX_PATTERN];
    logic [BYTE_W-1:0]    history     [MAX_PATTERN];
    logic [MAX_PATTERN-1:0] entry_loaded;
    logic [POS_BITS-1:0]  scan_pos;
    logic                 found_flag;
    logic [LEN_CFG_W-1:0] cfg_len;
    logic                 cfg_aligned;

    t_scan_result pending_results[$];
    int error_count   = 0;
    int checked_count = 0;
    int match_count   = 0;
    int sent_beats    = 0;
    int phase_count   = 0;
    int region_count  = 0;
    int in_run_left   = 0;
    int out_run_left  = 0;

    function automatic int active_length();
        if (cfg_len == 0) return 1;
        if (cfg_len > MAX_PATTERN) return MAX_PATTERN;
        return int'(cfg_len);
    endfunction

    // Scans must never compare against an entry that was never loaded
    function automatic bit pattern_ready();
        for (int j = 0; j < active_length(); j++)
            if (!entry_loaded[j]) return 1'b0;
        return 1'b1;
    endfunction

    function automatic void clear_window();
        foreach (history[k]) history[k] = '0;
        scan_pos   = '0;
        found_flag = 1'b0;
    endfunction

    // Advance the predicted state by one beat and return the result it causes
    function automatic t_scan_result predict_scan(t_beat b);
        t_scan_result r;
        int len;
        logic [POS_BITS-1:0] start;
        bit hit;
        r = '0;
        case (b.action)
            ACT_LOAD: begin
                pat_value[b.pattern_index]    = b.pattern_value;
                pat_mask[b.pattern_index]     = b.pattern_mask;
                entry_loaded[b.pattern_index] = 1'b1;
            end
            ACT_RESTART: clear_window();
            ACT_SCAN: begin
                len = active_length();
                for (int k = MAX_PATTERN - 1; k > 0; k--) history[k] = history[k-1];
                history[0] = b.data_byte;
                // a saturated position still shifts the window but never matches
                if (scan_pos != '1) begin
                    if (!found_flag && scan_pos + 1 >= len) begin
                        start = scan_pos + 1 - len;
                        hit = !cfg_aligned || (start % ALIGN_STEP) == 0;
                        for (int j = 0; j < len; j++)
                            if ((history[len-1-j] & pat_mask[j]) != (pat_value[j] & pat_mask[j]))
                                hit = 1'b0;
                        if (hit) begin
                            found_flag     = 1'b1;
                            r.match_found  = 1'b1;
                            r.match_offset = start;
                        end
                    end
                    scan_pos = scan_pos + 1;
                end
                r.search_done = r.match_found | b.is_last;
            end
            default: ;
        endcase
        return r;
    endfunction

    // Wait before one beat: drawn at random, with occasional runs of back-to-back beats
    function automatic int draw_wait(inout int run_left);
        if (run_left > 0) begin
            run_left--;
            return 0;
        end
        if ($urandom_range(0, 29) == 0) begin
            run_left = $urandom_range(10, 40);
            return 0;
        end
        return $urandom_range(0, 15);
    endfunction

    function automatic t_beat rand_beat(logic [ACTION_W-1:0] act);
        logic [63:0] bits64;
        t_beat b;
        bits64   = {$urandom, $urandom};
        b        = bits64[$bits(t_beat)-1:0];
        b.action = act;
        return b;
    endfunction

    function automatic t_row beat_row(logic [ACTION_W-1:0] act, logic [PIDX_W-1:0] idx,
                                      logic [BYTE_W-1:0] val, logic [BYTE_W-1:0] msk,
                                      logic [BYTE_W-1:0] data, logic last, logic typed,
                                      logic found, logic [OFFSET_W-1:0] off, logic done);
        t_row r;
        r      = '0;
        r.beat = '{act, idx, val, msk, data, last};
        r.typed = typed;
        r.want  = '{found, off, done};
        return r;
    endfunction

    function automatic t_row cfg_row(logic do_len, logic [CFG_W-1:0] len_val,
                                     logic do_align, logic [CFG_W-1:0] align_val);
        t_row r;
        r           = '0;
        r.do_len    = do_len;
        r.len_val   = len_val;
        r.do_align  = do_align;
        r.align_val = align_val;
        return r;
    endfunction

    // Drive one input beat from a falling edge; record its expectation on acceptance
    task automatic send_beat(t_beat b, logic typed, t_scan_result want);
        int gap;
        t_scan_result predicted;
        gap = draw_wait(in_run_left);
        if (gap > 0) begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_ch.valid         <= 1'b1;
        in_ch.action        <= b.action;
        in_ch.pattern_index <= b.pattern_index;
        in_ch.pattern_value <= b.pattern_value;
        in_ch.pattern_mask  <= b.pattern_mask;
        in_ch.data_byte     <= b.data_byte;
        in_ch.is_last       <= b.is_last;
        do @(posedge clk); while (in_ch.ready !== 1'b1);
        predicted = predict_scan(b);
        pending_results.push_back(typed ? want : predicted);
        if (b.action != ACT_UNUSED) sent_beats++;
        @(negedge clk);
    endtask

    // Register writes happen only once every result is back
    task automatic write_regs(logic do_len, logic [CFG_W-1:0] len_val,
                              logic do_align, logic [CFG_W-1:0] align_val);
        in_ch.valid <= 1'b0;
        while (pending_results.size() != 0) @(negedge clk);
        if (do_len) begin
            cfg_we    <= 1'b1;
            cfg_index <= CFG_PATTERN_LENGTH;
            cfg_data  <= len_val;
            cfg_len    = len_val[LEN_CFG_W-1:0];
            @(negedge clk);
        end
        if (do_align) begin
            cfg_we      <= 1'b1;
            cfg_index   <= CFG_ALIGNED_STARTS;
            cfg_data    <= align_val;
            cfg_aligned  = align_val[0];
            @(negedge clk);
        end
        cfg_we <= 1'b0;
    endtask

    // One region: optional restart, random bytes with the pattern often planted, last flag, optional tail
    task automatic scan_region();
        logic [BYTE_W-1:0] bytes[$];
        int len, n, s, reps, tail;
        t_beat b;
        len = active_length();
        n   = $urandom_range(1, 2 * len + 8);
        repeat (n) bytes.push_back(BYTE_W'($urandom));
        reps = ($urandom_range(0, 3) == 0) ? 2 : 1;
        if (n >= len && $urandom_range(0, 9) < 7) begin
            repeat (reps) begin
                s = $urandom_range(0, n - len);
                if (cfg_aligned && $urandom_range(0, 4) != 0) s = s - s % ALIGN_STEP;
                for (int j = 0; j < len; j++)
                    bytes[s+j] = (pat_value[j] & pat_mask[j])
                                 | (BYTE_W'($urandom) & ~pat_mask[j]);
            end
        end
        // most regions start clean; some run on from the previous one
        if ($urandom_range(0, 9) != 0) send_beat(rand_beat(ACT_RESTART), PRED, '0);
        for (int k = 0; k < n; k++) begin
            case ($urandom_range(0, 39))
                0: send_beat(rand_beat(ACT_UNUSED), PRED, '0);
                1: send_beat(rand_beat(ACT_LOAD), PRED, '0);
                default: ;
            endcase
            b           = rand_beat(ACT_SCAN);
            b.data_byte = bytes[k];
            b.is_last   = (k == n - 1);
            send_beat(b, PRED, '0);
        end
        // bytes after the end of the region
        if ($urandom_range(0, 4) == 0) begin
            tail = $urandom_range(1, 3);
            repeat (tail) send_beat(rand_beat(ACT_SCAN), PRED, '0);
        end
        region_count++;
    endtask

    // Stimulus
    initial begin
        t_row rows[$];
        t_beat b;
        logic [CFG_W-1:0] len_val;
        logic [CFG_W-1:0] align_val;
        int directed_beats;
        int regions;
        rst_n               = 1'b0;
        cfg_we              = 1'b0;
        cfg_index           = '0;
        cfg_data            = '0;
        in_ch.valid         = 1'b0;
        in_ch.action        = ACT_LOAD;
        in_ch.pattern_index = '0;
        in_ch.pattern_value = '0;
        in_ch.pattern_mask  = '0;
        in_ch.data_byte     = '0;
        in_ch.is_last       = 1'b0;
        cfg_len      = LEN_CFG_W'(1);
        cfg_aligned  = 1'b0;
        entry_loaded = '0;
        foreach (pat_value[k]) begin
            pat_value[k] = '0;
            pat_mask[k]  = '0;
        end
        clear_window();
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed table, reset settings: length 1, any start
        rows.push_back(beat_row(ACT_LOAD,    0, 8'hA5, 8'hFF, 0, 0, TYPED, 0, 0, 0));
        rows.push_back(beat_row(ACT_SCAN,    0, 0, 0, 8'h00, 0, TYPED, 0, 0, 0));
        rows.push_back(beat_row(ACT_SCAN,    0, 0, 0, 8'hA5, 0, TYPED, 1, 1, 1));
        // after the first match only the last flag still reports
        rows.push_back(beat_row(ACT_SCAN,    0, 0, 0, 8'hA5, 1, TYPED, 0, 0, 1));
        rows.push_back(beat_row(ACT_UNUSED,  0, 0, 0, 0, 0, TYPED, 0, 0, 0));
        rows.push_back(beat_row(ACT_RESTART, 0, 0, 0, 0, 0, TYPED, 0, 0, 0));
        rows.push_back(beat_row(ACT_SCAN,    0, 0, 0, 8'hA5, 1, TYPED, 1, 0, 1));
        // nibble wildcard
        rows.push_back(beat_row(ACT_LOAD,    0, 8'h3C, 8'hF0, 0, 0, TYPED, 0, 0, 0));
        rows.push_back(beat_row(ACT_RESTART, 0, 0, 0, 0, 0, TYPED, 0, 0, 0));
        rows.push_back(beat_row(ACT_SCAN,    0, 0, 0, 8'h3F, 0, TYPED, 1, 0, 1));
        // full wildcard
        rows.push_back(beat_row(ACT_LOAD,    0, 8'hFF, 8'h00, 0, 0, TYPED, 0, 0, 0));
        rows.push_back(beat_row(ACT_RESTART, 0, 0, 0, 0, 0, TYPED, 0, 0, 0));
        rows.push_back(beat_row(ACT_SCAN,    0, 0, 0, 8'h00, 0, TYPED, 1, 0, 1));
        rows.push_back(beat_row(ACT_LOAD,   31, 8'hFF, 8'hFF, 0, 0, TYPED, 0, 0, 0));
        rows.push_back(beat_row(ACT_LOAD,    1, 8'h22, 8'hFF, 0, 0, TYPED, 0, 0, 0));
        rows.push_back(beat_row(ACT_LOAD,    0, 8'h11, 8'hFF, 0, 0, TYPED, 0, 0, 0));
        // two byte pattern: nothing before two bytes have arrived
        rows.push_back(cfg_row(1'b1, 6'd2, 1'b0, '0));
        rows.push_back(beat_row(ACT_RESTART, 0, 0, 0, 0, 0, TYPED, 0, 0, 0));
        rows.push_back(beat_row(ACT_SCAN,    0, 0, 0, 8'h11, 0, TYPED, 0, 0, 0));
        rows.push_back(beat_row(ACT_SCAN,    0, 0, 0, 8'h22, 0, TYPED, 1, 0, 1));
        // aligned starts: the hit at offset 1 is skipped, the one at 4 is taken
        rows.push_back(cfg_row(1'b0, '0, 1'b1, 6'd1));
        rows.push_back(beat_row(ACT_RESTART, 0, 0, 0, 0, 0, TYPED, 0, 0, 0));
        rows.push_back(beat_row(ACT_SCAN,    0, 0, 0, 8'h00, 0, PRED, 0, 0, 0));
        rows.push_back(beat_row(ACT_SCAN,    0, 0, 0, 8'h11, 0, PRED, 0, 0, 0));
        rows.push_back(beat_row(ACT_SCAN,    0, 0, 0, 8'h22, 0, TYPED, 0, 0, 0));
        rows.push_back(beat_row(ACT_SCAN,    0, 0, 0, 8'h00, 0, PRED, 0, 0, 0));
        rows.push_back(beat_row(ACT_SCAN,    0, 0, 0, 8'h11, 0, PRED, 0, 0, 0));
        rows.push_back(beat_row(ACT_SCAN,    0, 0, 0, 8'h22, 1, TYPED, 1, 4, 1));
        rows.push_back(beat_row(ACT_SCAN,    0, 0, 0, 8'h00, 1, TYPED, 0, 0, 1));

        foreach (rows[i]) begin
            if (rows[i].do_len || rows[i].do_align)
                write_regs(rows[i].do_len, rows[i].len_val, rows[i].do_align, rows[i].align_val);
            else
                send_beat(rows[i].beat, rows[i].typed, rows[i].want);
        end
        directed_beats = sent_beats;

        // Random phases; the first ones hit the length and alignment extremes
        while (sent_beats - directed_beats < RANDOM_BEATS) begin
            case (phase_count)
                0: begin len_val = 6'd32; align_val = 6'd0; end
                1: begin len_val = 6'd63; align_val = 6'd1; end
                2: begin len_val = 6'd0;  align_val = 6'h3F; end
                3: begin len_val = 6'd1;  align_val = 6'h3E; end
                default: begin
                    len_val   = ($urandom_range(0, 3) != 0) ? CFG_W'($urandom_range(1, 8))
                                                            : CFG_W'($urandom_range(0, 63));
                    align_val = CFG_W'($urandom);
                end
            endcase
            write_regs(1'b1, len_val, 1'b1, align_val);
            phase_count++;
            // fresh pattern, or keep the old one across the length change
            if (!pattern_ready() || $urandom_range(0, 1) == 0) begin
                for (int j = 0; j < active_length(); j++) begin
                    b               = rand_beat(ACT_LOAD);
                    b.pattern_index = PIDX_W'(j);
                    case ($urandom_range(0, 4))
                        0: b.pattern_mask = 8'hFF;
                        1: b.pattern_mask = 8'hF0;
                        2: b.pattern_mask = 8'h0F;
                        3: b.pattern_mask = 8'h00;
                        default: ;
                    endcase
                    send_beat(b, PRED, '0);
                end
            end
            regions = $urandom_range(3, 6);
            repeat (regions) scan_region();
        end

        // Drain
        in_ch.valid <= 1'b0;
        while (pending_results.size() != 0) @(negedge clk);
        repeat (10) @(posedge clk);

        $display("summary: %0d beats in %0d settings and %0d regions (%0d directed)",
                 sent_beats, phase_count, region_count, directed_beats);
        $display("summary: %0d results checked, %0d matches, %0d mismatches",
                 checked_count, match_count, error_count);
        if (error_count == 0)
            $display("tb: PASS");
        else
            $display("tb: FAIL");
        $finish;
    end

    // Result side: random stalls, every beat checked against the oldest expectation
    initial begin
        t_scan_result got;
        t_scan_result want;
        int stall;
        out_ch.ready = 1'b0;
        wait (rst_n === 1'b1);
        @(negedge clk);
        forever begin
            stall = draw_wait(out_run_left);
            if (stall > 0) begin
                out_ch.ready <= 1'b0;
                repeat (stall) @(negedge clk);
            end
            out_ch.ready <= 1'b1;
            do @(posedge clk); while (out_ch.valid !== 1'b1);
            got = '{out_ch.match_found, out_ch.match_offset, out_ch.search_done};
            if (pending_results.size() == 0) begin
                $error("result beat with nothing expected");
                error_count++;
            end else begin
                want = pending_results.pop_front();
                checked_count++;
                if (got.match_found !== want.match_found) begin
                    $error("match_found: expected %0d, got %0d",
                           want.match_found, got.match_found);
                    error_count++;
                end
                if (got.match_offset !== want.match_offset) begin
                    $error("match_offset: expected %0d, got %0d",
                           want.match_offset, got.match_offset);
                    error_count++;
                end
                if (got.search_done !== want.search_done) begin
                    $error("search_done: expected %0d, got %0d",
                           want.search_done, got.search_done);
                    error_count++;
                end
                if (got.match_found === 1'b1) match_count++;
            end
            @(negedge clk);
        end
    end

    // Watchdog
    initial begin
        #5000000;
        $display("tb: FAIL");
        $finish;
    end

endmodule
